// File: sv/lzw_compress_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// LZW decoder assertion macros
// Shared implication macros for the concurrent checks of the decoder.
// ----------------------------------------------------------------------------
`ifndef LZW_COMPRESS_DECODER_TOP_DEFINES_SVH
`define LZW_COMPRESS_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define LZWD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzwd check failed");

// next-cycle implication
`define LZWD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzwd check failed");

`endif

// File: sv/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Types, codes and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int MaxCodeBitsDefault = 16;

  localparam logic [1:0] MODE_PUSH    = 2'd0;
  localparam logic [1:0] MODE_PULL    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MAGIC    = 2'd1;
  localparam logic [1:0] ERR_MAXBITS  = 2'd2;
  localparam logic [1:0] ERR_CODE     = 2'd3;
  localparam logic [2:0] ST_REFUSED   = 3'd4;

  localparam logic [1:0] SKIP_NONE    = 2'd0;
  localparam logic [1:0] SKIP_WIDEN   = 2'd1;
  localparam logic [1:0] SKIP_CLEAR   = 2'd2;

  localparam logic [1:0] PH_MAGIC0    = 2'd0;
  localparam logic [1:0] PH_MAGIC1    = 2'd1;
  localparam logic [1:0] PH_STYLE     = 2'd2;
  localparam logic [1:0] PH_DATA      = 2'd3;

  localparam logic [7:0] MAGIC0       = 8'h1F;
  localparam logic [7:0] MAGIC1       = 8'h9D;
  localparam logic [4:0] MIN_WIDTH    = 5'd9;
  localparam logic [4:0] WIDTH_CAP    = 5'd16;
  localparam logic [15:0] CODE_CLEAR  = 16'd256;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       string_end;
    logic       more_pending;
    logic [2:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WALK_RD, S_WALK_DATA, S_WALK_END, S_PATCH, S_PULL, S_FINISH
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic walk_data;
    logic walk_end;
    logic patch;
    logic pull_cap;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic go_walk;
    logic go_end;
    logic go_pull;
    logic walk_more;
    logic patch_pend;
    logic out_free;
  } stat_t;

endpackage

// File: sv/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// LZW decoder controller
// Sequences one request through decode, chain walk, pull and result load.
// ----------------------------------------------------------------------------
module lzwd_ctrl
  import lzwd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_ready,
  input  stat_t  st,
  output cmd_t   cmd,
  output state_t state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (st.go_walk)      state_next = S_WALK_RD;
        else if (st.go_end)  state_next = S_WALK_END;
        else if (st.go_pull) state_next = S_PULL;
        else                 state_next = S_FINISH;
      end
      S_WALK_RD:   state_next = S_WALK_DATA;
      S_WALK_DATA: state_next = st.walk_more ? S_WALK_RD : S_WALK_END;
      S_WALK_END:  state_next = st.patch_pend ? S_PATCH : S_FINISH;
      S_PATCH:     state_next = S_FINISH;
      S_PULL:      state_next = S_FINISH;
      S_FINISH: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    req_ready     = (state == S_IDLE);
    cmd.latch     = (state == S_IDLE) && req_valid;
    cmd.exec      = (state == S_EXEC);
    cmd.walk_data = (state == S_WALK_DATA);
    cmd.walk_end  = (state == S_WALK_END);
    cmd.patch     = (state == S_PATCH);
    cmd.pull_cap  = (state == S_PULL);
    cmd.finish    = (state == S_FINISH) && st.out_free;
  end

endmodule

// File: sv/lzwd_dp.sv
// ----------------------------------------------------------------------------
// LZW decoder datapath
// Header and bit unpacking, dictionary and output stack memories, result reg.
// ----------------------------------------------------------------------------
module lzwd_dp
  import lzwd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MaxCodeBitsDefault
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  cmd_t  cmd,
  output stat_t st,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output rsp_t  rsp
);

  localparam int Depth = 1 << MAX_CODE_BITS;
  localparam int AW    = MAX_CODE_BITS;
  localparam int LW    = MAX_CODE_BITS + 1;

  logic [15:0] prefix_mem [Depth];
  logic [7:0]  suffix_mem [Depth];
  logic [7:0]  stack_mem  [Depth];
  logic [15:0] prefix_q;
  logic [7:0]  suffix_q;
  logic [7:0]  stack_q;

  logic [1:0]  mode_q;
  logic [7:0]  byte_q;
  logic [LW-1:0] level;
  logic [23:0] bitbuf;
  logic [4:0]  held;
  logic [4:0]  cw;
  logic [16:0] highest;
  logic [15:0] top;
  logic        clr_en;
  logic [1:0]  phase;
  logic [2:0]  cm8;
  logic [1:0]  skip;
  logic        owed;
  logic [15:0] owed_e;
  logic [1:0]  err;
  logic [15:0] t;
  logic [15:0] code_c;
  logic        patch_pend;
  logic [AW-1:0] patch_idx;
  logic [7:0]  r_ob;
  logic        r_valid;
  logic        r_send;
  logic        r_refused;

  logic [23:0] buf_cat;
  logic [4:0]  held_sum;
  logic        have_code;
  logic [15:0] code;
  logic [2:0]  cm8_inc;
  logic        is_push;
  logic        data_take;
  logic        is_clear;
  logic        do_decode;
  logic        bad;
  logic [LW-1:0] level_m1;
  logic [16:0] h_new;
  logic [16:0] pow;
  logic        grow;
  logic        st_we;
  logic [AW-1:0] st_wa;
  logic [7:0]  st_wd;
  logic [4:0]  mb;

  always_comb begin
    buf_cat   = bitbuf | ({16'd0, byte_q} << held);
    held_sum  = held + 5'd8;
    have_code = (held_sum >= cw);
    code      = 16'(buf_cat & ((24'd1 << cw) - 24'd1));
    cm8_inc   = cm8 + 3'd1;
    is_push   = (mode_q == MODE_PUSH) && (err == ERR_NONE) && (level == '0);
    data_take = is_push && (phase == PH_DATA) && have_code;
    is_clear  = (code == CODE_CLEAR) && clr_en;
    do_decode = data_take && (skip == SKIP_NONE) && !is_clear;
    bad       = ({1'b0, code} > highest);
    level_m1  = level - LW'(1);
    mb        = byte_q[4:0];
    h_new     = (highest < {1'b0, top}) ? highest + 17'd1 : highest;
    pow       = 17'd1 << cw;
    grow      = (cw < WIDTH_CAP) && (pow <= {1'b0, top}) && (pow <= h_new);
  end

  always_comb begin
    st.go_walk    = do_decode && !bad && (code >= CODE_CLEAR);
    st.go_end     = do_decode && !bad && (code < CODE_CLEAR);
    st.go_pull    = (mode_q == MODE_PULL) && (level != '0);
    st.walk_more  = (prefix_q >= CODE_CLEAR);
    st.patch_pend = patch_pend;
    st.out_free   = !rsp_valid || rsp_ready;
  end

  // stack write port
  always_comb begin
    st_we = 1'b0;
    st_wa = level[AW-1:0];
    st_wd = t[7:0];
    if (cmd.walk_data) begin
      st_we = 1'b1;
      st_wd = suffix_q;
    end else if (cmd.walk_end) begin
      st_we = 1'b1;
    end else if (cmd.patch) begin
      st_we = 1'b1;
      st_wa = patch_idx;
    end
  end

  always_ff @(posedge clk) begin
    prefix_q <= prefix_mem[t[AW-1:0]];
    suffix_q <= suffix_mem[t[AW-1:0]];
    stack_q  <= stack_mem[level_m1[AW-1:0]];
    if (st_we) stack_mem[st_wa] <= st_wd;
    if (cmd.walk_end) begin
      if (owed) suffix_mem[owed_e[AW-1:0]] <= t[7:0];
      if (highest < {1'b0, top}) prefix_mem[h_new[AW-1:0]] <= code_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= req.mode;
      byte_q <= req.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= '0;
      bitbuf     <= '0;
      held       <= '0;
      cw         <= MIN_WIDTH;
      highest    <= 17'd255;
      top        <= '0;
      clr_en     <= 1'b0;
      phase      <= PH_MAGIC0;
      cm8        <= '0;
      skip       <= SKIP_NONE;
      owed       <= 1'b0;
      owed_e     <= '0;
      err        <= ERR_NONE;
      patch_pend <= 1'b0;
      r_valid    <= 1'b0;
      r_send     <= 1'b0;
      r_refused  <= 1'b0;
      r_ob       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        r_ob       <= '0;
        r_valid    <= 1'b0;
        r_send     <= 1'b0;
        r_refused  <= 1'b0;
        patch_pend <= 1'b0;
        if (mode_q == MODE_RESTART) begin
          level   <= '0;
          bitbuf  <= '0;
          held    <= '0;
          cw      <= MIN_WIDTH;
          highest <= 17'd255;
          top     <= '0;
          clr_en  <= 1'b0;
          phase   <= PH_MAGIC0;
          cm8     <= '0;
          skip    <= SKIP_NONE;
          owed    <= 1'b0;
          owed_e  <= '0;
          err     <= ERR_NONE;
        end else if (mode_q == MODE_PUSH && err == ERR_NONE) begin
          if (level != '0) begin
            r_refused <= 1'b1;
          end else begin
            unique case (phase)
              PH_MAGIC0: begin
                if (byte_q != MAGIC0) err <= ERR_MAGIC;
                else phase <= PH_MAGIC1;
              end
              PH_MAGIC1: begin
                if (byte_q != MAGIC1) err <= ERR_MAGIC;
                else phase <= PH_STYLE;
              end
              PH_STYLE: begin
                if (mb < MIN_WIDTH || mb > 5'(MAX_CODE_BITS)) begin
                  err <= ERR_MAXBITS;
                end else begin
                  clr_en  <= byte_q[7];
                  top     <= 16'((17'd1 << mb) - 17'd1);
                  highest <= 17'd255 + {16'd0, byte_q[7]};
                  cw      <= MIN_WIDTH;
                  phase   <= PH_DATA;
                end
              end
              default: begin
                bitbuf <= have_code ? (buf_cat >> cw) : buf_cat;
                held   <= have_code ? (held_sum - cw) : held_sum;
                if (have_code) begin
                  cm8 <= cm8_inc;
                  if (skip != SKIP_NONE) begin
                    if (cm8_inc == 3'd0) begin
                      cw   <= (skip == SKIP_WIDEN) ? cw + 5'd1 : MIN_WIDTH;
                      skip <= SKIP_NONE;
                    end
                  end else if (is_clear) begin
                    highest <= 17'd256;
                    owed    <= 1'b0;
                    if (cm8_inc == 3'd0) cw <= MIN_WIDTH;
                    else skip <= SKIP_CLEAR;
                  end else if (bad) begin
                    err <= ERR_CODE;
                  end else begin
                    t      <= code;
                    code_c <= code;
                  end
                end
              end
            endcase
          end
        end
      end

      if (cmd.walk_data) begin
        level <= level + LW'(1);
        t     <= prefix_q;
        if (owed && t == owed_e) begin
          patch_pend <= 1'b1;
          patch_idx  <= level[AW-1:0];
        end
      end

      if (cmd.walk_end) begin
        level <= level + LW'(1);
        owed  <= 1'b0;
        if (highest < {1'b0, top}) begin
          highest <= h_new;
          owed    <= 1'b1;
          owed_e  <= h_new[15:0];
        end
        if (grow) begin
          if (cm8 == 3'd0) cw <= cw + 5'd1;
          else skip <= SKIP_WIDEN;
        end
      end

      if (cmd.pull_cap) begin
        r_ob    <= stack_q;
        r_valid <= 1'b1;
        r_send  <= (level == LW'(1));
        level   <= level_m1;
      end

      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.out_byte     <= r_ob;
      rsp.out_valid    <= r_valid;
      rsp.string_end   <= r_send;
      rsp.more_pending <= (level != '0);
      rsp.status       <= r_refused ? ST_REFUSED : {1'b0, err};
    end
  end

endmodule

// File: sv/lzw_compress_decoder_top.sv
// ----------------------------------------------------------------------------
// LZW decoder top level
// Decoder for compress (.Z) streams: controller plus datapath.
// ----------------------------------------------------------------------------
// Use:
//   Request channel (req_valid/req_ready/req) carries a mode and a byte:
//   push a compressed byte, pull one decoded byte, or restart for a new
//   header. Every request yields exactly one response on rsp_valid/
//   rsp_ready/rsp with the decoded byte, flags and status.
// Sequencing:
//   Restart, refused push, header byte or byte without a full code: decode, then load.
//   Pull: one registered read of the output stack, then load.
//   Push completing a code: decode, chain walk, final stack write, then load;
//   each chain step is a registered read of the prefix/suffix memories
//   followed by a stack write. A KwKwK code adds a fix-up write to the stack.
//   A new request is taken only once the previous one has been loaded.
// Reset:
//   rst (synchronous) clears the decoder state; dictionary and stack
//   contents stay undefined until written, so no clearing pass is needed.
// Stall:
//   A finished response waits in the output register; the next request
//   is still taken and processed, holding at its final step until the
//   receiver takes the earlier response.
// ----------------------------------------------------------------------------
`include "lzw_compress_decoder_top_defines.svh"

module lzw_compress_decoder_top
  import lzwd_pkg::*;
#(
  parameter int MAX_CODE_BITS = MaxCodeBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t   cmd;
  stat_t  st;
  state_t state;

  // sequencer
  lzwd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd),
    .state     (state)
  );

  // state, memories and response register
  lzwd_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // a taken request keeps the block busy for at least the next cycle
  `LZWD_ASSERT_NXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)
  // a result load always leaves a response on offer
  `LZWD_ASSERT_NXT(a_load_shows, clk, rst, state == S_FINISH && st.out_free, rsp_valid)
  // the last byte of a string empties the stack
  `LZWD_ASSERT_NOW(a_end_empty, clk, rst, rsp_valid && rsp.string_end,
                   rsp.out_valid && !rsp.more_pending)
  // a refused push only happens with output pending
  `LZWD_ASSERT_NOW(a_refuse_pending, clk, rst, rsp_valid && rsp.status == ST_REFUSED,
                   rsp.more_pending)

endmodule

// File: tb/lzw_compress_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// LZW decoder top-level testbench
// Drives push, pull and restart requests at the decoder, with random bursts
// and receiver stalls. A scoreboard class predicts every response from its
// own copy of the decoder state and compares each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lzw_compress_decoder_top_tb;
  import lzwd_pkg::*;

  // Response predictor and store of expected responses
  class lzw_scoreboard;
    logic [15:0] prefix_mem [0:65535];
    logic [7:0]  suffix_mem [0:65535];
    logic [7:0]  stack_mem  [0:65535];
    int unsigned depth, bitbuf, nbits, width, last_entry, limit;
    int unsigned clr_en, phase, grp, skip, owed, owed_idx, err;
    rsp_t        pending_rsps[$];
    int          errors;
    int          checked;
    int          bytes_out;

    function void restart();
      depth = 0; bitbuf = 0; nbits = 0; width = 9; last_entry = 255;
      limit = 0; clr_en = 0; phase = PH_MAGIC0; grp = 0; skip = SKIP_NONE;
      owed = 0; owed_idx = 0; err = ERR_NONE;
    endfunction

    function int unsigned first_char(int unsigned c);
      while (c >= 256) c = prefix_mem[c];
      return c & 8'hFF;
    endfunction

    function void decode(int unsigned c);
      int unsigned t;
      t = c;
      if (c > last_entry) begin
        err = ERR_CODE;
        return;
      end
      if (owed) begin
        suffix_mem[owed_idx] = 8'(first_char(c));
        owed = 0;
      end
      while (t >= 256 && depth < 65536) begin
        stack_mem[depth] = suffix_mem[t];
        depth++;
        t = prefix_mem[t];
      end
      if (depth < 65536) begin
        stack_mem[depth] = t[7:0];
        depth++;
      end
      if (last_entry < limit) begin
        last_entry++;
        prefix_mem[last_entry] = c[15:0];
        owed = 1;
        owed_idx = last_entry;
      end
      if (width < 16 && (1 << width) <= limit && (1 << width) <= last_entry) begin
        if (grp == 0) width++;
        else skip = SKIP_WIDEN;
      end
    endfunction

    function void take_code(int unsigned c);
      grp = (grp + 1) & 7;
      if (skip != SKIP_NONE) begin
        if (grp == 0) begin
          if (skip == SKIP_WIDEN) width++;
          else width = 9;
          skip = SKIP_NONE;
        end
        return;
      end
      if (c == CODE_CLEAR && clr_en) begin
        last_entry = 256;
        owed = 0;
        if (grp == 0) width = 9;
        else skip = SKIP_CLEAR;
        return;
      end
      decode(c);
    endfunction

    function void push(logic [7:0] b);
      int unsigned mb, c;
      case (phase)
        PH_MAGIC0: if (b != MAGIC0) err = ERR_MAGIC; else phase = PH_MAGIC1;
        PH_MAGIC1: if (b != MAGIC1) err = ERR_MAGIC; else phase = PH_STYLE;
        PH_STYLE: begin
          mb = 32'(b & 8'h1F);
          if (mb < 9 || mb > 16) begin
            err = ERR_MAXBITS;
          end else begin
            clr_en = b[7] ? 1 : 0;
            limit = (1 << mb) - 1;
            last_entry = 255 + clr_en;
            width = 9;
            phase = PH_DATA;
          end
        end
        default: begin
          bitbuf = (bitbuf | (int'(b) << nbits)) & 24'hFFFFFF;
          nbits += 8;
          if (nbits >= width) begin
            c = bitbuf & ((1 << width) - 1);
            bitbuf >>= width;
            nbits -= width;
            take_code(c);
          end
        end
      endcase
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(req_t r);
      rsp_t e;
      e = '0;
      if (r.mode == MODE_RESTART) restart();
      else if (r.mode == MODE_PULL && depth > 0) begin
        depth--;
        e.out_byte = stack_mem[depth];
        e.out_valid = 1'b1;
        e.string_end = (depth == 0);
      end
      e.status = 3'(err);
      if (r.mode == MODE_PUSH && err == ERR_NONE) begin
        if (depth > 0) e.status = ST_REFUSED;
        else begin
          push(r.in_byte);
          e.status = 3'(err);
        end
      end
      e.more_pending = (depth > 0);
      pending_rsps.push_back(e);
    endfunction

    // one line per mismatch, counted
    task report(string what, int unsigned got, int unsigned want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    // check an accepted response against the oldest expectation
    task check(rsp_t got);
      rsp_t want;
      if (pending_rsps.size() == 0) begin
        report("unexpected response", 32'(got), 0);
        return;
      end
      want = pending_rsps.pop_front();
      checked++;
      if (got.out_byte != want.out_byte)
        report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
      if (got.out_valid != want.out_valid)
        report("out_valid", 32'(got.out_valid), 32'(want.out_valid));
      if (got.string_end != want.string_end)
        report("string_end", 32'(got.string_end), 32'(want.string_end));
      if (got.more_pending != want.more_pending)
        report("more_pending", 32'(got.more_pending), 32'(want.more_pending));
      if (got.status != want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.out_valid) bytes_out++;
    endtask

    function bit busy();
      return depth > 0;
    endfunction

    function bit is_data();
      return phase == PH_DATA && err == ERR_NONE;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  lzw_scoreboard sb;
  int unsigned   cycle_count = 0;
  int            n_sent = 0;
  int            stall_mode;
  bit            stim_done = 1'b0;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1700;

  lzw_compress_decoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // responses sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      cycle_count++;
      if (rsp_valid && rsp_ready) sb.check(rsp);
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("lzw_compress_decoder_top regression: fail");
        $finish;
      end
    end
  end

  // receiver stall pattern: switches between always ready, sparse and random
  always @(negedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // send one request on the next falling edge, with a random gap in front at times
  task automatic send(logic [1:0] mode, logic [7:0] b);
    req_t r;
    r.mode = mode;
    r.in_byte = b;
    @(negedge clk);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    n_sent++;
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  // push a byte, then pull every decoded byte it produced
  task automatic push_drain(logic [7:0] b);
    send(MODE_PUSH, b);
    while (sb.busy()) send(MODE_PULL, 8'h00);
  endtask

  task automatic header(logic [7:0] style);
    send(MODE_RESTART, 8'($urandom));
    push_drain(MAGIC0);
    push_drain(MAGIC1);
    push_drain(style);
  endtask

  // LSB-first packing of one random stream of codes at the predicted width;
  // stops early once stop_at requests have gone out
  task automatic code_stream(int ncodes, bit use_clear, int stop_at);
    int unsigned acc, nacc, c, w;
    acc = 0; nacc = 0;
    for (int i = 0; i < ncodes; i++) begin
      if (n_sent >= stop_at) return;
      w = sb.width;
      if (sb.skip != SKIP_NONE) c = $urandom & ((1 << w) - 1);
      else if (use_clear && sb.clr_en && $urandom_range(0, 40) == 0) c = CODE_CLEAR;
      else if ($urandom_range(0, 3) == 0 && sb.last_entry >= 256)
        c = $urandom_range(sb.last_entry - ((sb.last_entry > 260) ? 4 : 0), sb.last_entry);
      else if ($urandom_range(0, 200) == 0) c = (sb.last_entry + 1) & ((1 << w) - 1);
      else c = $urandom_range(0, 255);
      acc |= c << nacc;
      nacc += w;
      while (nacc >= 8) begin
        push_drain(acc[7:0]);
        acc >>= 8;
        nacc -= 8;
        if (!sb.is_data()) return;
      end
      if (sb.width != w && nacc > 0) begin
        // width changed mid-byte: drop the partial code and carry on from here
        acc = 0; nacc = 0;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.restart();
    sb.errors = 0;
    sb.checked = 0;
    sb.bytes_out = 0;
    stall_mode = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: header errors, unused mode, empty pull, refused push, bad code
    send(MODE_PULL, 8'h00);
    send(2'd3, 8'hFF);
    push_drain(8'h00);
    push_drain(8'hFF);
    send(MODE_RESTART, 8'h00);
    push_drain(MAGIC0);
    push_drain(8'h62);
    header(8'h08);
    header(8'h11);
    header(8'h89);
    // codes 'A', 1 and 2 at 9 bits, with a push refused while output is pending
    push_drain(8'h41);
    send(MODE_PUSH, 8'h02);
    send(MODE_PUSH, 8'h02);
    while (sb.busy()) send(MODE_PULL, 8'h00);
    push_drain(8'h08);
    push_drain(8'h10);
    // code beyond last entry then everything after is latched
    push_drain(8'hFF);
    push_drain(8'hFF);
    send(MODE_PULL, 8'h00);
    send(MODE_PUSH, 8'h55);
    header(8'h90);

    // random: mostly well-formed streams, some noise and broken headers
    while (n_sent < 1000) begin
      case ($urandom_range(0, 9))
        0: begin
          send(2'($urandom_range(0, 3)), 8'($urandom));
        end
        1: header(8'($urandom));
        default: begin
          header({1'($urandom_range(0, 1)), 2'b00, 5'($urandom_range(9, 16))});
          code_stream($urandom_range(10, 160), 1'b1, 1000);
        end
      endcase
    end
    // small-dictionary run towards a full table at the widest code
    header(8'h09);
    code_stream(700, 1'b0, ITEM_TARGET);
    stim_done = 1'b1;
  end

  // end of run once every expected response has arrived
  initial begin
    wait (stim_done);
    while (sb.pending_rsps.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d requests sent, %0d responses checked, %0d decoded bytes pulled",
             n_sent, sb.checked, sb.bytes_out);
    $display("streams covered header errors, clear, widening, KwKwK and bad codes");
    if (sb.errors == 0 && sb.pending_rsps.size() == 0)
      $display("lzw_compress_decoder_top regression: pass");
    else
      $display("lzw_compress_decoder_top regression: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/lzwd_pkg.sv
sv/lzwd_ctrl.sv
sv/lzwd_dp.sv
sv/lzw_compress_decoder_top.sv
tb/lzw_compress_decoder_top_tb.sv
